FILE: src/tsme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsme_pkg;
    typedef enum logic [2:0] {
        CMD_CONTAINS = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_LIST     = 3'd4,
        CMD_UNION    = 3'd5,
        CMD_INTER    = 3'd6,
        CMD_DIFF     = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [2:0]   cmd;
        logic         set_sel;
        logic [31:0]  value;
    } t_req;

    typedef struct packed {
        logic         ok;
        logic         full_res;
        logic [31:0]  element;
        logic         element_valid;
        logic         last;
        logic [4:0]   set_count;
    } t_res;
endpackage
`default_nettype wire

FILE: src/tsme_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tsme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/tsme_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// holds both tables, their counts, and the operand registers
module tsme_datapath #(
    parameter int MAX_ENTRIES = 16,
    parameter int AW = $clog2(MAX_ENTRIES),
    parameter int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ld_req,
    input  wire tsme_pkg::t_req i_req,
    input  wire logic          i_rd_sel,   // table to read
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic          i_wr_sel,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic          i_wr_from_rd, // write last read word, else request value
    input  wire logic          i_cnt_inc,
    input  wire logic          i_cnt_dec,
    input  wire logic          i_cnt_clr,
    input  wire logic          i_hold_ld,  // capture read word as probe
    output tsme_pkg::t_req     o_req,
    output logic [31:0]        o_rd_data,
    output logic [31:0]        o_hold,
    output logic [CW-1:0]      o_cnt_a,
    output logic [CW-1:0]      o_cnt_b
);
    import tsme_pkg::*;

    t_req          r_req;
    logic [31:0]   r_hold;
    logic [CW-1:0] r_cnt [2];
    logic [31:0]   w_rd [2];
    logic [31:0]   w_wdata;

    assign w_wdata = i_wr_from_rd ? o_rd_data : r_req.value;

    for (genvar g = 0; g < 2; g++) begin : g_tab
        tsme_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_wr_en && (i_wr_sel == 1'(g))),
            .i_waddr(i_wr_addr),
            .i_wdata(w_wdata),
            .i_raddr(i_rd_addr),
            .o_rdata(w_rd[g])
        );
    end

    logic r_rd_sel;
    always_ff @(posedge i_clk) begin
        r_rd_sel <= i_rd_sel;
        if (!i_rst_n) begin
            r_req <= '0;
        end else if (i_ld_req) begin
            r_req <= i_req;
        end
        if (i_hold_ld) begin
            r_hold <= o_rd_data;
        end
    end
    assign o_rd_data = w_rd[r_rd_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
        end else if (i_cnt_clr) begin
            r_cnt[r_req.set_sel] <= '0;
        end else if (i_cnt_inc) begin
            r_cnt[r_req.set_sel] <= r_cnt[r_req.set_sel] + CW'(1);
        end else if (i_cnt_dec) begin
            r_cnt[r_req.set_sel] <= r_cnt[r_req.set_sel] - CW'(1);
        end
    end

    assign o_req   = r_req;
    assign o_hold  = r_hold;
    assign o_cnt_a = r_cnt[r_req.set_sel];
    assign o_cnt_b = r_cnt[!r_req.set_sel];
endmodule
`default_nettype wire

FILE: src/tsme_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tsme_ctrl #(
    parameter int MAX_ENTRIES = 16,
    parameter int AW = $clog2(MAX_ENTRIES),
    parameter int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire tsme_pkg::t_req i_req_q,
    input  wire logic [31:0]    i_rd_data,
    input  wire logic [31:0]    i_hold,
    input  wire logic [CW-1:0]  i_cnt_a,
    input  wire logic [CW-1:0]  i_cnt_b,
    output logic                o_busy,
    output logic                o_ld_req,
    output logic                o_rd_sel,
    output logic [AW-1:0]       o_rd_addr,
    output logic                o_wr_en,
    output logic                o_wr_sel,
    output logic [AW-1:0]       o_wr_addr,
    output logic                o_wr_from_rd,
    output logic                o_cnt_inc,
    output logic                o_cnt_dec,
    output logic                o_cnt_clr,
    output logic                o_hold_ld,
    output logic                o_strobe,
    output tsme_pkg::t_res      o_res
);
    import tsme_pkg::*;

    // scan: i walks table X looking for probe; outer loop j feeds probes for set ops
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_DECIDE, S_SHIFT, S_FETCH, S_FETCH_W,
        S_INNER, S_EMIT, S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_i, r_j;      // inner / outer indices
    logic          r_phase;       // union: 0 = A list, 1 = B against A
    logic          r_found;
    logic [AW-1:0] r_pos;
    logic          r_rvalid;      // read data valid for index r_i-1
    logic          r_any;         // any element emitted
    logic          r_strobe;
    t_res          r_res;

    logic          w_sel;
    logic [CW-1:0] w_inner_cnt;
    logic          w_inner_tab;
    logic [31:0]   w_probe;
    t_cmd          w_cmd;

    assign w_sel = i_req_q.set_sel;
    assign w_cmd = t_cmd'(i_req_q.cmd);
    // the table scanned for the probe
    assign w_inner_tab = (w_cmd == CMD_INTER || w_cmd == CMD_DIFF) ? !w_sel : w_sel;
    assign w_inner_cnt = (w_cmd == CMD_INTER || w_cmd == CMD_DIFF) ? i_cnt_b : i_cnt_a;
    assign w_probe = (w_cmd inside {CMD_CONTAINS, CMD_ADD, CMD_REMOVE}) ? i_req_q.value : i_hold;

    always_comb begin
        o_busy       = (r_state != S_IDLE);
        o_ld_req     = (r_state == S_IDLE) && i_start;
        o_rd_sel     = w_inner_tab;
        o_rd_addr    = r_i[AW-1:0];
        o_wr_en      = 1'b0;
        o_wr_sel     = w_sel;
        o_wr_addr    = r_i[AW-1:0];
        o_wr_from_rd = 1'b0;
        o_cnt_inc    = 1'b0;
        o_cnt_dec    = 1'b0;
        o_cnt_clr    = 1'b0;
        o_hold_ld    = 1'b0;
        case (r_state)
            S_FETCH: begin
                o_rd_sel  = (w_cmd == CMD_UNION && r_phase) ? !w_sel : w_sel;
                o_rd_addr = r_j[AW-1:0];
            end
            S_FETCH_W: o_hold_ld = 1'b1;
            S_SHIFT: begin
                o_rd_sel  = w_sel;
                o_rd_addr = r_i[AW-1:0];
                o_wr_en   = r_rvalid;
                o_wr_from_rd = 1'b1;
                o_wr_addr = AW'(r_i - CW'(2));
                o_cnt_dec = (r_i >= i_cnt_a);
            end
            S_DECIDE: begin
                if (w_cmd == CMD_ADD && !r_found && i_cnt_a < CW'(MAX_ENTRIES)) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = i_cnt_a[AW-1:0];
                    o_cnt_inc = 1'b1;
                end
                if (w_cmd == CMD_CLEAR) begin
                    o_cnt_clr = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_phase  <= 1'b0;
            r_found  <= 1'b0;
            r_pos    <= '0;
            r_rvalid <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_i      <= '0;
                    r_j      <= '0;
                    r_phase  <= 1'b0;
                    r_found  <= 1'b0;
                    r_rvalid <= 1'b0;
                    r_any    <= 1'b0;
                    if (w_cmd inside {CMD_CONTAINS, CMD_ADD, CMD_REMOVE}) begin
                        r_state <= S_SCAN;
                    end else if (w_cmd == CMD_CLEAR) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (w_cmd == CMD_UNION && r_phase ? (r_j >= i_cnt_b)
                                                      : (r_j >= i_cnt_a)) begin
                        if (w_cmd == CMD_UNION && !r_phase) begin
                            r_phase <= 1'b1;
                            r_j     <= '0;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_FETCH_W;
                    end
                end
                S_FETCH_W: begin
                    r_i      <= '0;
                    r_found  <= 1'b0;
                    r_rvalid <= 1'b0;
                    // list and the first union phase emit without a scan
                    if (w_cmd == CMD_LIST || (w_cmd == CMD_UNION && !r_phase)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INNER;
                    end
                end
                S_SCAN, S_INNER: begin
                    // read of entry r_i issued; data for r_i-1 arrives now
                    if (r_rvalid && !r_found && i_rd_data == w_probe) begin
                        r_found <= 1'b1;
                        r_pos   <= AW'(r_i - CW'(1));
                    end
                    if (r_found || (r_rvalid && i_rd_data == w_probe)
                        || r_i >= w_inner_cnt) begin
                        r_state  <= (r_state == S_SCAN) ? S_DECIDE : S_EMIT;
                        r_rvalid <= 1'b0;
                    end else begin
                        r_i      <= r_i + CW'(1);
                        r_rvalid <= 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (w_cmd == CMD_REMOVE && r_found) begin
                        r_i      <= CW'(r_pos) + CW'(1);
                        r_rvalid <= 1'b0;
                        r_state  <= S_SHIFT;
                    end else begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        r_res.ok <= (w_cmd == CMD_CLEAR) ? 1'b1
                                    : r_found ? 1'b0 + (w_cmd != CMD_ADD)
                                    : (w_cmd == CMD_ADD && i_cnt_a < CW'(MAX_ENTRIES));
                        r_res.full_res <= (w_cmd == CMD_ADD) && !r_found
                                          && (i_cnt_a >= CW'(MAX_ENTRIES));
                        r_res.element  <= '0;
                        r_res.element_valid <= 1'b0;
                        r_res.last     <= 1'b1;
                        r_res.set_count <= (w_cmd == CMD_CLEAR) ? 5'd0
                            : (w_cmd == CMD_ADD && !r_found && i_cnt_a < CW'(MAX_ENTRIES))
                              ? 5'(i_cnt_a + CW'(1)) : 5'(i_cnt_a);
                    end
                end
                S_SHIFT: begin
                    // move entry r_i-1 down to r_i-2 once its read returns
                    if (r_i >= i_cnt_a) begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        r_res.ok <= 1'b1;
                        r_res.full_res <= 1'b0;
                        r_res.element  <= '0;
                        r_res.element_valid <= 1'b0;
                        r_res.last     <= 1'b1;
                        r_res.set_count <= 5'(i_cnt_a - CW'(1));
                    end else begin
                        r_i      <= r_i + CW'(1);
                        r_rvalid <= 1'b1;
                    end
                end
                S_EMIT: begin
                    r_j <= r_j + CW'(1);
                    r_state <= S_FETCH;
                    if ((w_cmd == CMD_LIST) || (w_cmd == CMD_UNION && !r_phase)
                        || ((w_cmd == CMD_INTER) == r_found)) begin
                        // result goes out when the next element or done replaces it, so last can be known
                        if (r_any) begin
                            r_strobe <= 1'b1;
                        end
                        r_any <= 1'b1;
                        r_res.ok <= 1'b1;
                        r_res.full_res <= 1'b0;
                        r_res.element  <= i_hold;
                        r_res.element_valid <= 1'b1;
                        r_res.last     <= 1'b0;
                        r_res.set_count <= 5'(i_cnt_a);
                    end
                end
                S_DONE: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                    r_res.ok <= 1'b1;
                    r_res.full_res <= 1'b0;
                    r_res.last <= 1'b1;
                    r_res.set_count <= 5'(i_cnt_a);
                    if (!r_any) begin
                        r_res.element <= '0;
                        r_res.element_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a held element goes out when the next one replaces it; emit with a held element sets the pending strobe
    logic r_pend_strobe;
    t_res r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_strobe <= 1'b0;
        end else begin
            r_pend_strobe <= 1'b0;
            if (r_state == S_EMIT && r_any && ((w_cmd == CMD_LIST)
                || (w_cmd == CMD_UNION && !r_phase) || ((w_cmd == CMD_INTER) == r_found))) begin
                r_pend_strobe <= 1'b1;
            end
        end
        if (r_state == S_EMIT) begin
            r_out <= r_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = (r_pend_strobe) ? r_out : r_res;

    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.last) |=> !r_strobe) else $error("strobe after last");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (o_busy || r_res.last)) else $error("result while idle");
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cnt_a <= CW'(MAX_ENTRIES))) else $error("count overflow");
endmodule
`default_nettype wire

FILE: src/two_set_membership_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-set membership engine. Pulse start with a request while busy is low;
// results come out one per o_valid pulse and cannot be stalled, the final one
// marked last. Contains, add and remove scan the selected table for the value;
// list, union, intersection and difference fetch the elements of a table one
// by one and, but for list and the first union phase, scan the other table
// for each, since each table has a single read port.
module two_set_membership_engine_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire tsme_pkg::t_req i_req,
    output logic                busy,
    output logic                o_valid,
    output tsme_pkg::t_res      o_res
);
    import tsme_pkg::*;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_req r_q;
    logic [31:0] w_rd, w_hold;
    logic [CW-1:0] w_ca, w_cb;
    logic w_ld, w_rsel, w_we, w_wsel, w_wfr, w_inc, w_dec, w_clr, w_hl;
    logic [AW-1:0] w_ra, w_wa;

    tsme_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ld_req(w_ld), .i_req(i_req),
        .i_rd_sel(w_rsel), .i_rd_addr(w_ra), .i_wr_en(w_we), .i_wr_sel(w_wsel),
        .i_wr_addr(w_wa), .i_wr_from_rd(w_wfr), .i_cnt_inc(w_inc), .i_cnt_dec(w_dec),
        .i_cnt_clr(w_clr), .i_hold_ld(w_hl), .o_req(r_q), .o_rd_data(w_rd),
        .o_hold(w_hold), .o_cnt_a(w_ca), .o_cnt_b(w_cb)
    );

    tsme_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req_q(r_q),
        .i_rd_data(w_rd), .i_hold(w_hold), .i_cnt_a(w_ca), .i_cnt_b(w_cb),
        .o_busy(busy), .o_ld_req(w_ld), .o_rd_sel(w_rsel), .o_rd_addr(w_ra),
        .o_wr_en(w_we), .o_wr_sel(w_wsel), .o_wr_addr(w_wa), .o_wr_from_rd(w_wfr),
        .o_cnt_inc(w_inc), .o_cnt_dec(w_dec), .o_cnt_clr(w_clr), .o_hold_ld(w_hl),
        .o_strobe(o_valid), .o_res(o_res)
    );
endmodule
`default_nettype wire
